// ===== src/obf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obf_pkg
// Shared types and constants for the two-sided price-ordered book.
// ----------------------------------------------------------------------------
package obf_pkg;

   localparam int BOOK_DEPTH  = 16;
   localparam int PRICE_BITS  = 16;
   localparam int QTY_BITS    = 16;
   localparam int MAX_RESULTS = 16;
   localparam int CNT_BITS    = $clog2(BOOK_DEPTH + 1);
   localparam int KCNT_BITS   = $clog2(MAX_RESULTS + 1);
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_INS_BID  = 2'd0,
      OP_INS_ASK  = 2'd1,
      OP_TAKE_BID = 2'd2,
      OP_TAKE_ASK = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_FILL    = 2'd0,
      ST_INS_OK  = 2'd1,
      ST_FULL    = 2'd2,
      ST_NO_FILL = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_TAKE   = 2'd1,
      CMD_REJECT = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic                  is_bid;
      logic [PRICE_BITS-1:0] price;
      logic [QTY_BITS-1:0]   quantity;
   } cmd_type;

   typedef struct packed {
      status_type            status;
      logic [PRICE_BITS-1:0] fill_price;
      logic [QTY_BITS-1:0]   fill_quantity;
      logic                  last;
   } rsp_type;

   typedef enum logic [0:0] {
      BK_IDLE = 1'b0,
      BK_TAKE = 1'b1
   } bk_state_type;

endpackage

// ===== src/obf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obf_front
// Accept words, classify them and queue commands for the back end. Flag
// takes of zero quantity as rejects; book occupancy is checked in the back end.
// ----------------------------------------------------------------------------
module obf_front import obf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [1:0]            req_operation,
   input  logic [PRICE_BITS-1:0] req_price,
   input  logic [QTY_BITS-1:0]   req_quantity,
   output logic                  cmd_valid,
   output cmd_type               cmd_word,
   input  logic                  cmd_pop
);

   cmd_type              queue_ff [QUEUE_DEPTH];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           fill_ff, fill_in;
   cmd_type              cmd_new;
   logic                 accept;
   op_type               op;

   assign op       = op_type'(req_operation);
   assign req_full = (fill_ff == 2'(QUEUE_DEPTH));
   assign accept   = req_push && !req_full;

   // The empty-book check for takes is done in the back end where the live count is known.
   always_comb begin
      cmd_new.price    = req_price;
      cmd_new.quantity = req_quantity;
      unique case (op)
         OP_INS_BID:  begin cmd_new.kind = CMD_INSERT; cmd_new.is_bid = 1'b1; end
         OP_INS_ASK:  begin cmd_new.kind = CMD_INSERT; cmd_new.is_bid = 1'b0; end
         OP_TAKE_BID: begin
            cmd_new.kind   = (req_quantity == '0) ? CMD_REJECT : CMD_TAKE;
            cmd_new.is_bid = 1'b1;
         end
         default: begin
            cmd_new.kind   = (req_quantity == '0) ? CMD_REJECT : CMD_TAKE;
            cmd_new.is_bid = 1'b0;
         end
      endcase
   end

   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd_word  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ accept;
      rd_ptr_in = rd_ptr_ff ^ (cmd_pop && cmd_valid);
      fill_in   = fill_ff + 2'(accept) - 2'(cmd_pop && cmd_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 2'(QUEUE_DEPTH)) else $error("command queue overflow");
   assert property (@(posedge clock) disable iff (reset)
      (fill_ff == 2'd0) |-> (wr_ptr_ff == rd_ptr_ff)) else $error("pointer skew");
   assert property (@(posedge clock) disable iff (reset)
      (accept && !(cmd_pop && cmd_valid)) |=> (fill_ff == $past(fill_ff) + 2'd1))
      else $error("fill count lost a word");

endmodule

// ===== src/obf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obf_back
// Hold both books, run commands: sorted shift insert, one fill per cycle for
// takes while there is room, results into a two-entry output queue.
// ----------------------------------------------------------------------------
module obf_back import obf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  cmd_type               cmd_word,
   output logic                  cmd_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [1:0]            rsp_status,
   output logic [PRICE_BITS-1:0] rsp_fill_price,
   output logic [QTY_BITS-1:0]   rsp_fill_quantity,
   output logic                  rsp_last
);

   logic [PRICE_BITS-1:0] bp_ff [BOOK_DEPTH];
   logic [QTY_BITS-1:0]   bq_ff [BOOK_DEPTH];
   logic [PRICE_BITS-1:0] ap_ff [BOOK_DEPTH];
   logic [QTY_BITS-1:0]   aq_ff [BOOK_DEPTH];
   logic [CNT_BITS-1:0]   bcnt_ff, bcnt_in, acnt_ff, acnt_in;

   bk_state_type          state_ff, state_in;
   logic                  side_ff, side_in;
   logic [QTY_BITS-1:0]   want_ff, want_in;
   logic [KCNT_BITS-1:0]  k_ff, k_in;

   rsp_type               oq_ff [2];
   logic                  owr_ff, ord_ff;
   logic [1:0]            ofill_ff;
   logic                  opush;
   rsp_type               onew;

   logic                  do_ins, do_pop_b, do_pop_a, do_red;
   logic [QTY_BITS-1:0]   red_qty;
   logic [CNT_BITS-1:0]   cur_cnt;
   logic [PRICE_BITS-1:0] head_p;
   logic [QTY_BITS-1:0]   head_q;
   logic [BOOK_DEPTH-1:0] behind;
   logic                  room;

   assign room    = (ofill_ff == 2'd0) || (ofill_ff == 2'd1 && rsp_pop);
   assign cur_cnt = side_ff ? bcnt_ff : acnt_ff;
   assign head_p  = side_ff ? bp_ff[0] : ap_ff[0];
   assign head_q  = side_ff ? bq_ff[0] : aq_ff[0];

   // Position mask: entry i lies behind the new one.
   always_comb begin
      for (int i = 0; i < BOOK_DEPTH; i++) begin
         if (cmd_word.is_bid)
            behind[i] = (CNT_BITS'(i) < bcnt_ff) && (bp_ff[i] < cmd_word.price);
         else
            behind[i] = (CNT_BITS'(i) < acnt_ff) && (ap_ff[i] > cmd_word.price);
      end
   end

   always_comb begin
      state_in = state_ff;
      side_in  = side_ff;
      want_in  = want_ff;
      k_in     = k_ff;
      cmd_pop  = 1'b0;
      opush    = 1'b0;
      onew     = '{status: ST_FILL, fill_price: '0, fill_quantity: '0, last: 1'b1};
      do_ins   = 1'b0;
      do_pop_b = 1'b0;
      do_pop_a = 1'b0;
      do_red   = 1'b0;
      red_qty  = '0;
      bcnt_in  = bcnt_ff;
      acnt_in  = acnt_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && room) begin
               cmd_pop = 1'b1;
               opush   = 1'b1;
               unique case (cmd_word.kind)
                  CMD_INSERT: begin
                     if ((cmd_word.is_bid ? bcnt_ff : acnt_ff) ==
                         CNT_BITS'(BOOK_DEPTH)) begin
                        onew.status = ST_FULL;
                     end else begin
                        onew.status = ST_INS_OK;
                        do_ins      = 1'b1;
                        if (cmd_word.is_bid) bcnt_in = bcnt_ff + 1'b1;
                        else                 acnt_in = acnt_ff + 1'b1;
                     end
                  end
                  CMD_TAKE: begin
                     if ((cmd_word.is_bid ? bcnt_ff : acnt_ff) == '0) begin
                        onew.status = ST_NO_FILL;
                     end else begin
                        opush    = 1'b0;
                        side_in  = cmd_word.is_bid;
                        want_in  = cmd_word.quantity;
                        k_in     = '0;
                        state_in = BK_TAKE;
                     end
                  end
                  default: onew.status = ST_NO_FILL;
               endcase
            end
         end
         default: begin
            if (room) begin
               opush           = 1'b1;
               onew.status     = ST_FILL;
               onew.fill_price = head_p;
               k_in            = k_ff + 1'b1;
               if (head_q <= want_ff) begin
                  onew.fill_quantity = head_q;
                  want_in            = want_ff - head_q;
                  if (side_ff) begin do_pop_b = 1'b1; bcnt_in = bcnt_ff - 1'b1; end
                  else         begin do_pop_a = 1'b1; acnt_in = acnt_ff - 1'b1; end
                  onew.last = (want_in == '0) || (cur_cnt == CNT_BITS'(1)) ||
                              (k_in == KCNT_BITS'(MAX_RESULTS));
               end else begin
                  onew.fill_quantity = want_ff;
                  do_red             = 1'b1;
                  red_qty            = head_q - want_ff;
                  want_in            = '0;
                  onew.last          = 1'b1;
               end
               if (onew.last) state_in = BK_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         bcnt_ff  <= '0;
         acnt_ff  <= '0;
         owr_ff   <= 1'b0;
         ord_ff   <= 1'b0;
         ofill_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         bcnt_ff  <= bcnt_in;
         acnt_ff  <= acnt_in;
         owr_ff   <= owr_ff ^ opush;
         ord_ff   <= ord_ff ^ (rsp_pop && !rsp_empty);
         ofill_ff <= ofill_ff + 2'(opush) - 2'(rsp_pop && !rsp_empty);
      end
   end

   always_ff @(posedge clock) begin
      side_ff <= side_in;
      want_ff <= want_in;
      k_ff    <= k_in;
      if (opush) oq_ff[owr_ff] <= onew;
   end

   // Book storage: sorted shift on insert, shift toward head on removal.
   always_ff @(posedge clock) begin
      for (int i = 0; i < BOOK_DEPTH; i++) begin
         if (do_ins && cmd_word.is_bid) begin
            if (behind[i]) begin
               if (i > 0) begin
                  bp_ff[i] <= behind[i-1] ? bp_ff[i-1] : cmd_word.price;
                  bq_ff[i] <= behind[i-1] ? bq_ff[i-1] : cmd_word.quantity;
               end else begin
                  bp_ff[i] <= cmd_word.price;
                  bq_ff[i] <= cmd_word.quantity;
               end
            end else if (CNT_BITS'(i) == bcnt_ff) begin
               if (i > 0 && behind[i-1]) begin
                  bp_ff[i] <= bp_ff[i-1];
                  bq_ff[i] <= bq_ff[i-1];
               end else begin
                  bp_ff[i] <= cmd_word.price;
                  bq_ff[i] <= cmd_word.quantity;
               end
            end
         end else if (do_pop_b && i < BOOK_DEPTH-1) begin
            bp_ff[i] <= bp_ff[i+1];
            bq_ff[i] <= bq_ff[i+1];
         end
         if (do_ins && !cmd_word.is_bid) begin
            if (behind[i]) begin
               if (i > 0) begin
                  ap_ff[i] <= behind[i-1] ? ap_ff[i-1] : cmd_word.price;
                  aq_ff[i] <= behind[i-1] ? aq_ff[i-1] : cmd_word.quantity;
               end else begin
                  ap_ff[i] <= cmd_word.price;
                  aq_ff[i] <= cmd_word.quantity;
               end
            end else if (CNT_BITS'(i) == acnt_ff) begin
               if (i > 0 && behind[i-1]) begin
                  ap_ff[i] <= ap_ff[i-1];
                  aq_ff[i] <= aq_ff[i-1];
               end else begin
                  ap_ff[i] <= cmd_word.price;
                  aq_ff[i] <= cmd_word.quantity;
               end
            end
         end else if (do_pop_a && i < BOOK_DEPTH-1) begin
            ap_ff[i] <= ap_ff[i+1];
            aq_ff[i] <= aq_ff[i+1];
         end
      end
      if (do_red) begin
         if (side_ff) bq_ff[0] <= red_qty;
         else         aq_ff[0] <= red_qty;
      end
   end

   assign rsp_empty         = (ofill_ff == 2'd0);
   assign rsp_status        = oq_ff[ord_ff].status;
   assign rsp_fill_price    = oq_ff[ord_ff].fill_price;
   assign rsp_fill_quantity = oq_ff[ord_ff].fill_quantity;
   assign rsp_last          = oq_ff[ord_ff].last;

   assert property (@(posedge clock) disable iff (reset)
      (bcnt_ff <= CNT_BITS'(BOOK_DEPTH)) && (acnt_ff <= CNT_BITS'(BOOK_DEPTH)))
      else $error("book count out of range");
   assert property (@(posedge clock) disable iff (reset)
      ofill_ff <= 2'd2) else $error("result queue overflow");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_TAKE) |-> !cmd_pop) else $error("command taken mid-take");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_TAKE) |-> (cur_cnt != '0)) else $error("take on empty book");

endmodule

// ===== src/order_book_fill.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_book_fill
// Two price-ordered books (bids best-high, asks best-low, FIFO on ties).
//
// Request side is a queue: push a word when full is low; operation selects
// insert bid/ask or take from bids/asks, quantity is the insert size or the
// amount to take. Result side is a queue: while empty is low the oldest
// result is on rsp_*, pop removes it. Every request gives one or more
// results; the final one carries rsp_last.
// Flow: a pushed word is registered in the command queue; the back end takes
// it and registers each result in the result queue. Insert, rejected insert
// and empty take give one result; a take has a start step with no result,
// then one fill per step while the result queue has room, up to 16 fills.
// The back end runs one word at a time; the two-entry command queue lets
// the front keep accepting while a take is in progress.
// Reset empties both books and both queues. While a result waits unpopped
// the back end holds; once the command queue fills, full rises.
// ----------------------------------------------------------------------------
module order_book_fill import obf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [1:0]            req_operation,
   input  logic [PRICE_BITS-1:0] req_price,
   input  logic [QTY_BITS-1:0]   req_quantity,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [1:0]            rsp_status,
   output logic [PRICE_BITS-1:0] rsp_fill_price,
   output logic [QTY_BITS-1:0]   rsp_fill_quantity,
   output logic                  rsp_last
);

   logic    cmd_valid, cmd_pop;
   cmd_type cmd_word;

   obf_front u_front (
      .clock, .reset, .req_push, .req_full, .req_operation, .req_price,
      .req_quantity, .cmd_valid, .cmd_word, .cmd_pop
   );

   obf_back u_back (
      .clock, .reset, .cmd_valid, .cmd_word, .cmd_pop, .rsp_empty, .rsp_pop,
      .rsp_status, .rsp_fill_price, .rsp_fill_quantity, .rsp_last
   );

endmodule
